/* rtl/first_fit_block_allocator_top_assert.svh */
// Assertion macros for the first-fit block allocator.
// Included by modules that check their own sequencing; no other dependencies.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define FFBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define FFBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ffba_pkg.sv */
// Shared types and constants for the first-fit block allocator.
// No dependencies; imported by the top level.
package ffba_pkg;

    localparam int POOL_BYTES_MAX_DEF = 4096;
    localparam int WORD_BYTES_DEF     = 8;
    localparam int POOL_BYTES_MIN     = 32;

    localparam int REQ_TYPE_W  = 2;
    localparam int REQ_BYTES_W = 13;
    localparam int OFFSET_W    = 12;
    localparam int LARGEST_W   = 13;
    localparam int POOL_W      = 13;

    // request codes
    localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_QUERY = 2'd2;

    // header mark in bit 0
    localparam logic MARK_FREE  = 1'b0;
    localparam logic MARK_ALLOC = 1'b1;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0]  req_type;
        logic [REQ_BYTES_W-1:0] req_bytes;
        logic [OFFSET_W-1:0]    block_offset;
    } t_in_word;

    typedef struct packed {
        logic [OFFSET_W-1:0]  granted_offset;
        logic                 failed;
        logic [LARGEST_W-1:0] largest_bytes;
    } t_out_word;

endpackage

/* rtl/ffba_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ffba_div.sv */
// Divide by the word size: reciprocal multiply with one correction step.
// Also flags an exact quotient. No dependencies.
module ffba_div #(
    parameter int XW         = 14,
    parameter int WORD_BYTES = 8
) (
    input  logic [XW-1:0] i_x,
    output logic [XW-1:0] o_q,
    output logic          o_exact
);

    localparam logic [XW-1:0] RECIP = XW'((2 ** XW) / WORD_BYTES);
    localparam logic [XW-1:0] WB    = XW'(WORD_BYTES);

    logic [2*XW-1:0] prod;
    logic [XW-1:0]   q_est;
    logic [XW-1:0]   rem_est;
    logic [XW-1:0]   rem_fix;

    // estimate is low by at most one
    assign prod    = {{XW{1'b0}}, i_x} * {{XW{1'b0}}, RECIP};
    assign q_est   = prod[2*XW-1:XW];
    assign rem_est = i_x - q_est * WB;

    always_comb begin
        if (rem_est >= WB) begin
            o_q     = q_est + XW'(1);
            rem_fix = rem_est - WB;
        end else begin
            o_q     = q_est;
            rem_fix = rem_est;
        end
    end

    assign o_exact = (rem_fix == '0);

endmodule

/* rtl/first_fit_block_allocator_top.sv */
// First-fit block allocator with coalescing: sequencer, header RAM and divider.
// Depends on ffba_pkg, ffba_ram, ffba_div and the assertion macro header.
//
//  channel | direction | handshake               | word
//  --------+-----------+-------------------------+-----------------------------
//  in      | in        | i_in_valid / o_in_stall | t_in_word  (type, size, offset)
//  out     | out       | o_out_valid / i_out_stall | t_out_word (offset, failed, largest)
//  cfg     | in        | i_cfg_we                | pool_bytes, 13 bits
//
// One header is read from the single RAM read port per cycle. An allocate merges
// free runs in S_MRG, checks its size against the largest in S_EVAL, walks to the
// first fit in S_SRCH and writes any remainder in S_SPLIT; a query stops after S_EVAL;
// a free walks S_FREE to the target. Each then returns to S_IDLE for the next word.
// After reset and after each pool_bytes write S_INIT formats the pool (stall high).
// The output register holds one result; the next word is taken while it waits, and
// a second finished result waits in the done state until the first is taken.
`include "first_fit_block_allocator_top_assert.svh"

module first_fit_block_allocator_top
    import ffba_pkg::*;
#(
    parameter int POOL_BYTES_MAX = POOL_BYTES_MAX_DEF,
    parameter int WORD_BYTES     = WORD_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_word          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_word         o_out_data,
    input  logic              i_cfg_we,
    input  logic [POOL_W-1:0] i_cfg_data
);

    localparam int POOL_WORDS = POOL_BYTES_MAX / WORD_BYTES;
    localparam int AW  = $clog2(POOL_WORDS);
    localparam int CW  = $clog2(POOL_WORDS + 1);
    localparam int HW  = CW + 1;
    localparam int NW  = CW + 1;
    localparam int PBW = $clog2(POOL_BYTES_MAX + 1);
    localparam int DW  = (PBW > REQ_BYTES_W + 1) ? PBW : REQ_BYTES_W + 1;
    localparam int BYW = (PBW > LARGEST_W) ? PBW : LARGEST_W;

    typedef enum logic [8:0] {
        S_INIT  = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_PREP  = 9'b000000100,
        S_MRG   = 9'b000001000,
        S_EVAL  = 9'b000010000,
        S_SRCH  = 9'b000100000,
        S_SPLIT = 9'b001000000,
        S_FREE  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state          r_state, n_state;
    t_in_word        r_in, n_in;
    logic [PBW-1:0]  r_pool, n_pool;
    logic [CW-1:0]   r_wc, n_wc;
    logic [AW-1:0]   r_cur, n_cur;
    logic [AW-1:0]   r_rs, n_rs;
    logic            r_run, n_run;
    logic [CW-1:0]   r_best, n_best;
    logic [DW-1:0]   r_q, n_q;
    logic [AW-1:0]   r_split_addr, n_split_addr;
    logic [CW-1:0]   r_split_sz, n_split_sz;
    t_out_word       r_res, n_res;
    t_out_word       r_out, n_out;
    logic            r_ovalid, n_ovalid;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [HW-1:0]   ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [HW-1:0]   rd_data;

    logic [DW-1:0]   div_x;
    logic [DW-1:0]   div_q;
    logic            div_exact;

    logic [CW-1:0]   h_sz;
    logic            h_free;
    logic [NW-1:0]   nxt_raw, nxt_clamp;
    logic            nxt_end;
    logic [AW-1:0]   nxt_addr;
    logic [CW-1:0]   run_sz, cand, rem_sz;
    logic            fits, split_rem, split_ok;
    logic [NW-1:0]   split_raw;
    logic [DW-1:0]   cur_plus1;
    logic [BYW-1:0]  best_bytes, grant_bytes;
    logic [BYW-1:0]  cfg_ext, pool_sat;

    ffba_ram #(
        .WIDTH (HW),
        .DEPTH (POOL_WORDS)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    ffba_div #(
        .XW         (DW),
        .WORD_BYTES (WORD_BYTES)
    ) u_div (
        .i_x     (div_x),
        .o_q     (div_q),
        .o_exact (div_exact)
    );

    // header just read, and where the next one sits
    assign h_sz      = rd_data[HW-1:1];
    assign h_free    = (rd_data[0] == MARK_FREE);
    assign nxt_raw   = NW'(r_cur) + NW'(h_sz) + NW'(1);
    assign nxt_end   = (nxt_raw >= NW'(r_wc));
    assign nxt_clamp = nxt_end ? NW'(r_wc) : nxt_raw;
    assign nxt_addr  = nxt_raw[AW-1:0];
    assign run_sz    = CW'(nxt_clamp - NW'(r_rs) - NW'(1));

    assign cur_plus1 = DW'(r_cur) + DW'(1);
    assign fits      = h_free && (DW'(h_sz) >= r_q);
    assign rem_sz    = h_sz - CW'(r_q);
    assign split_rem = (rem_sz != '0);
    assign split_raw = NW'(r_cur) + NW'(r_q) + NW'(1);
    assign split_ok  = split_rem && (split_raw < NW'(r_wc));

    assign best_bytes  = BYW'(r_best) * BYW'(WORD_BYTES);
    assign grant_bytes = BYW'(cur_plus1) * BYW'(WORD_BYTES);

    // clamp the written pool size into range
    assign cfg_ext = BYW'(i_cfg_data);
    always_comb begin
        if (cfg_ext < BYW'(POOL_BYTES_MIN)) begin
            pool_sat = BYW'(POOL_BYTES_MIN);
        end else if (cfg_ext > BYW'(POOL_BYTES_MAX)) begin
            pool_sat = BYW'(POOL_BYTES_MAX);
        end else begin
            pool_sat = cfg_ext;
        end
    end

    // one divider serves pool formatting, size rounding and offset decoding
    always_comb begin
        if (r_state == S_INIT) begin
            div_x = DW'(r_pool);
        end else if (r_in.req_type == REQ_ALLOC) begin
            div_x = DW'(r_in.req_bytes) + DW'(WORD_BYTES - 1);
        end else begin
            div_x = DW'(r_in.block_offset);
        end
    end

    always_comb begin
        n_state      = r_state;
        n_in         = r_in;
        n_pool       = r_pool;
        n_wc         = r_wc;
        n_cur        = r_cur;
        n_rs         = r_rs;
        n_run        = r_run;
        n_best       = r_best;
        n_q          = r_q;
        n_split_addr = r_split_addr;
        n_split_sz   = r_split_sz;
        n_res        = r_res;
        n_out        = r_out;
        n_ovalid     = r_ovalid;
        ram_we       = 1'b0;
        ram_waddr    = r_cur;
        ram_wdata    = rd_data;
        ram_raddr    = AW'(1);
        cand         = h_sz;

        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_INIT: begin
                // lay the pool out as one free block after the pool header
                ram_we    = 1'b1;
                ram_waddr = AW'(1);
                ram_wdata = {CW'(div_q) - CW'(2), MARK_FREE};
                n_wc      = CW'(div_q);
                n_state   = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_data;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_q    = div_q;
                n_res  = '0;
                n_best = '0;
                n_run  = 1'b0;
                n_cur  = AW'(1);
                case (r_in.req_type)
                    REQ_ALLOC: n_state = S_MRG;
                    REQ_QUERY: n_state = S_MRG;
                    REQ_FREE: begin
                        if (div_exact && (r_in.block_offset != '0)) begin
                            n_state = S_FREE;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_MRG: begin
                if (h_free) begin
                    if (r_run) begin
                        // extend the open free run over this block
                        ram_we    = 1'b1;
                        ram_waddr = r_rs;
                        ram_wdata = {run_sz, MARK_FREE};
                        cand      = run_sz;
                    end else begin
                        n_rs  = r_cur;
                        n_run = 1'b1;
                    end
                    if (cand > r_best) begin
                        n_best = cand;
                    end
                end else begin
                    n_run = 1'b0;
                end
                if (nxt_end) begin
                    n_state = S_EVAL;
                end else begin
                    n_cur     = nxt_addr;
                    ram_raddr = nxt_addr;
                end
            end
            S_EVAL: begin
                n_res.largest_bytes = LARGEST_W'(best_bytes);
                if (r_in.req_type != REQ_ALLOC) begin
                    n_state = S_DONE;
                end else if ((r_q == '0) || (r_q > DW'(r_best))) begin
                    n_res.failed = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    n_cur   = AW'(1);
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (fits) begin
                    ram_we               = 1'b1;
                    ram_waddr            = r_cur;
                    ram_wdata            = {split_rem ? CW'(r_q) : h_sz, MARK_ALLOC};
                    n_res.granted_offset = OFFSET_W'(grant_bytes);
                    if (split_ok) begin
                        n_split_addr = split_raw[AW-1:0];
                        n_split_sz   = rem_sz - CW'(1);
                        n_state      = S_SPLIT;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (nxt_end) begin
                    n_res.failed = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    n_cur     = nxt_addr;
                    ram_raddr = nxt_addr;
                end
            end
            S_SPLIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_split_addr;
                ram_wdata = {r_split_sz, MARK_FREE};
                n_state   = S_DONE;
            end
            S_FREE: begin
                if (cur_plus1 == r_q) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_cur;
                    ram_wdata = {h_sz, MARK_FREE};
                    n_state   = S_DONE;
                end else if ((cur_plus1 > r_q) || nxt_end) begin
                    // drop: no block has its payload at this offset
                    n_state = S_DONE;
                end else begin
                    n_cur     = nxt_addr;
                    ram_raddr = nxt_addr;
                end
            end
            S_DONE: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_out    = r_res;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_pool  = PBW'(pool_sat);
            n_state = S_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_pool   <= PBW'(POOL_BYTES_MAX);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pool   <= n_pool;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in         <= n_in;
        r_wc         <= n_wc;
        r_cur        <= n_cur;
        r_rs         <= n_rs;
        r_run        <= n_run;
        r_best       <= n_best;
        r_q          <= n_q;
        r_split_addr <= n_split_addr;
        r_split_sz   <= n_split_sz;
        r_res        <= n_res;
        r_out        <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    `FFBA_ASSERT_IMP(a_walk_in_pool, i_clk, i_rst_n,
        (r_state == S_MRG || r_state == S_SRCH || r_state == S_FREE),
        (CW'(r_cur) < r_wc), "header walk left the pool")
    `FFBA_ASSERT_IMP(a_pool_hdr_kept, i_clk, i_rst_n, ram_we, (ram_waddr != '0),
        "write to the reserved pool header word")
    `FFBA_ASSERT_IMP(a_search_has_room, i_clk, i_rst_n, (r_state == S_SRCH),
        ((r_q != '0) && (r_q <= DW'(r_best))), "search started without a fitting block")
    `FFBA_ASSERT_IMP(a_run_behind_walk, i_clk, i_rst_n, (r_state == S_MRG && r_run),
        (r_rs < r_cur), "open free run does not precede the walk")
    `FFBA_ASSERT_NXT(a_split_then_done, i_clk, i_rst_n, (r_state == S_SPLIT && !i_cfg_we),
        (r_state == S_DONE), "split header write not followed by result")

endmodule
